>>> hw/rtl/mqsb_pkg.sv
package mqsb_pkg;

    localparam int DATA_W = 32;
    localparam int QID_W  = 2;
    localparam int S_USER_W = 1 + QID_W;
    localparam int M_USER_W = 1;

    typedef enum logic
    {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

>>> hw/rtl/multi_queue_shared_buffer_unit.sv
// multi_queue_shared_buffer_unit
// Several FIFO queues kept as linked lists in one shared buffer of SLOTS words.
// Input stream (s_*): s_tdata carries the push word, s_tuser the kind (push or pop)
// and the queue number. A word is taken when s_tvalid and s_tready are high.
// Output stream (m_*): one result word per input word; m_tuser is the ok flag,
// m_tdata the popped word (zero for pushes and refused operations).
// A push is refused when no slot is free, a pop when the queue is empty, and both
// when the queue number is at or above QUEUES.
// Each word is a read and then an update of the link and data memories: the input
// word and the memory read are registered, then the update step writes the memories
// and the result registers that drive m_*; no input word is taken during the update.
// The next input word is taken while a result waits, as long as the result is
// taken in the same cycle; a stalled receiver holds the result and s_tready stays
// low until it drains.
// Reset: all queues empty, every slot free. Slots never used are tracked by a
// fill counter, so no clearing pass runs and the block is ready right after reset.
module multi_queue_shared_buffer_unit #(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mqsb_pkg::DATA_W-1:0]   s_tdata,   // push_value
    input  logic [mqsb_pkg::S_USER_W-1:0] s_tuser,   // kind, queue_id
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mqsb_pkg::DATA_W-1:0]   m_tdata,   // pop_value
    output logic [mqsb_pkg::M_USER_W-1:0] m_tuser    // ok
);

    import mqsb_pkg::*;

    localparam int AW  = $clog2(SLOTS);
    localparam int PW  = $clog2(SLOTS + 1);
    localparam int NQ  = (QUEUES < (1 << QID_W)) ? QUEUES : (1 << QID_W);
    localparam int QIW = (NQ > 1) ? $clog2(NQ) : 1;
    localparam logic [PW-1:0] NIL = PW'(SLOTS);

    logic [DATA_W-1:0] data_mem [SLOTS];
    logic [PW-1:0]     link_mem [SLOTS];

    state_t            state_reg, state_next;
    kind_t             op_kind_reg;
    logic [QID_W-1:0]  op_q_reg;
    logic [DATA_W-1:0] op_value_reg;
    logic [PW-1:0]     free_head_reg;
    logic [PW-1:0]     fill_reg;
    logic [PW-1:0]     head_reg [NQ];
    logic [PW-1:0]     tail_reg [NQ];
    logic [PW-1:0]     link_rd_reg;
    logic [DATA_W-1:0] data_rd_reg;
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [DATA_W-1:0] out_data_reg;

    logic              s_accept;
    kind_t             in_kind;
    logic [QID_W-1:0]  in_q;
    logic              in_q_ok;
    logic [PW-1:0]     rd_ptr;
    logic [AW-1:0]     rd_addr;

    logic              exec;
    logic              q_ok;
    logic [QIW-1:0]    qi;
    logic [PW-1:0]     head_q;
    logic [PW-1:0]     tail_q;
    logic              fresh;
    logic              ok;
    logic [DATA_W-1:0] result;
    logic              link_we;
    logic [AW-1:0]     link_wa;
    logic [PW-1:0]     link_wd;
    logic              data_we;
    logic [AW-1:0]     data_wa;
    logic              head_we;
    logic [PW-1:0]     head_wd;
    logic              tail_we;
    logic [PW-1:0]     tail_wd;
    logic              free_we;
    logic [PW-1:0]     free_wd;
    logic              fill_inc;

    // input side
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign in_kind  = kind_t'(s_tuser[0]);
    assign in_q     = s_tuser[QID_W:1];
    assign in_q_ok  = int'(in_q) < QUEUES;

    always_comb
    begin
        rd_ptr = free_head_reg;
        if (in_kind == KIND_POP)
        begin
            rd_ptr = in_q_ok ? head_reg[in_q[QIW-1:0]] : NIL;
        end
        rd_addr = (rd_ptr < NIL) ? rd_ptr[AW-1:0] : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // update step
    assign exec   = (state_reg == ST_EXEC);
    assign q_ok   = int'(op_q_reg) < QUEUES;
    assign qi     = op_q_reg[QIW-1:0];
    assign head_q = q_ok ? head_reg[qi] : NIL;
    assign tail_q = q_ok ? tail_reg[qi] : NIL;
    assign fresh  = free_head_reg >= fill_reg;

    always_comb
    begin
        ok       = 1'b0;
        result   = '0;
        link_we  = 1'b0;
        link_wa  = '0;
        link_wd  = free_head_reg;
        data_we  = 1'b0;
        data_wa  = free_head_reg[AW-1:0];
        head_we  = 1'b0;
        head_wd  = free_head_reg;
        tail_we  = 1'b0;
        tail_wd  = free_head_reg;
        free_we  = 1'b0;
        free_wd  = link_rd_reg;
        fill_inc = 1'b0;
        if (exec && q_ok)
        begin
            if (op_kind_reg == KIND_PUSH)
            begin
                if (free_head_reg < NIL)
                begin
                    ok       = 1'b1;
                    free_we  = 1'b1;
                    free_wd  = fresh ? (free_head_reg + PW'(1)) : link_rd_reg;
                    fill_inc = fresh;
                    data_we  = 1'b1;
                    tail_we  = 1'b1;
                    // the new tail's link is never read, so it is left as is
                    if (!(head_q < NIL))
                    begin
                        head_we = 1'b1;
                    end
                    else if (tail_q < NIL)
                    begin
                        link_we = 1'b1;
                        link_wa = tail_q[AW-1:0];
                        link_wd = free_head_reg;
                    end
                end
            end
            else
            begin
                if (head_q < NIL)
                begin
                    ok      = 1'b1;
                    result  = data_rd_reg;
                    head_we = 1'b1;
                    // popping the tail empties the queue
                    head_wd = (head_q == tail_q) ? NIL : link_rd_reg;
                    link_we = 1'b1;
                    link_wa = head_q[AW-1:0];
                    link_wd = free_head_reg;
                    free_we = 1'b1;
                    free_wd = head_q;
                end
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            link_rd_reg <= link_mem[rd_addr];
            data_rd_reg <= data_mem[rd_addr];
        end
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (data_we)
        begin
            data_mem[data_wa] <= op_value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_kind_reg  <= in_kind;
            op_q_reg     <= in_q;
            op_value_reg <= s_tdata;
        end
        if (exec)
        begin
            out_ok_reg   <= ok;
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            free_head_reg <= '0;
            fill_reg      <= '0;
            for (int i = 0; i < NQ; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (free_we)
            begin
                free_head_reg <= free_wd;
            end
            if (fill_inc)
            begin
                fill_reg <= fill_reg + PW'(1);
            end
            if (head_we)
            begin
                head_reg[qi] <= head_wd;
            end
            if (tail_we)
            begin
                tail_reg[qi] <= tail_wd;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

endmodule
